// ----- sv/csrmv_pkg.sv -----
// Shared types, constants and helpers for the CSR sparse matrix-vector row block.
// Used by csrmv_mac and the top level; depends on nothing else.
`default_nettype none

package csrmv_pkg;

  // Defaults for the top-level parameters
  localparam int VECTOR_DEPTH_DEF     = 4096;
  localparam int ROW_NUMBER_LIMIT_DEF = 65536;

  // Fixed field widths
  localparam int IDX_W     = 12;
  localparam int OPND_W    = 32;
  localparam int ROWNUM_W  = 16;
  localparam int SUM_W     = 64;
  localparam int CMD_W     = 2;
  localparam int S_TDATA_W = 48;   // index + operand, padded to whole bytes
  localparam int M_TDATA_W = 80;   // row_number + row_sum

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TERM  = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_t;

  // Control of an item that has read the vector memory
  typedef struct packed {
    logic valid;     // term or empty row in this stage
    logic term;      // nonzero term: adds a product
    logic finish;    // closes the row and emits a result
    logic in_range;  // column lies inside the vector store
  } rd_ctl_t;

  // Signed add that clamps to the 64-bit extremes
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/csrmv_vec_mem.sv -----
// Dense vector store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module csrmv_vec_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/csrmv_mac.sv -----
// Multiply stage, saturating row accumulator, row counter and output register.
// Depends on csrmv_pkg.
`default_nettype none

module csrmv_mac
  import csrmv_pkg::*;
#(
  parameter int ROW_NUMBER_LIMIT = ROW_NUMBER_LIMIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rd_ctl_t                    rd_ctl,
  input  wire logic signed [OPND_W-1:0]   rd_operand,
  input  wire logic signed [OPND_W-1:0]   vec_data,
  output      logic                       advance,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [ROWNUM_W-1:0]        out_row_number,
  output      logic signed [SUM_W-1:0]    out_row_sum
);

  localparam int ROW_W = (ROW_NUMBER_LIMIT > 1) ? $clog2(ROW_NUMBER_LIMIT) : 1;

  logic                    prod_valid;
  logic                    prod_term;
  logic                    prod_finish;
  logic signed [SUM_W-1:0] mult;
  logic signed [SUM_W-1:0] prod;
  logic signed [SUM_W-1:0] prod_next;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] sum;
  logic [ROW_W-1:0]        rows_done;
  logic [ROW_W-1:0]        rows_done_next;
  logic [31:0]             rows_wide;
  logic                    hold;

  always_comb begin
    // Sign-extend both factors so the product keeps its sign
    mult      = SUM_W'(rd_operand) * SUM_W'(vec_data);
    prod_next = (rd_ctl.term && rd_ctl.in_range) ? mult : '0;
    sum       = prod_term ? sat_add(acc, prod) : acc;
    hold      = prod_valid && prod_finish && out_valid && !out_ready;
    advance   = !hold;
    rows_done_next = (rows_done == ROW_W'(ROW_NUMBER_LIMIT - 1)) ? '0 : rows_done + 1'b1;
    rows_wide = 32'(rows_done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc        <= '0;
      rows_done  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (advance && prod_valid && prod_finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        prod_valid <= rd_ctl.valid;
        if (prod_valid) begin
          if (prod_finish) begin
            acc       <= '0;
            rows_done <= rows_done_next;
          end else begin
            acc <= sum;
          end
        end
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      prod_term   <= rd_ctl.term;
      prod_finish <= rd_ctl.finish;
      prod        <= prod_next;
      if (prod_valid && prod_finish) begin
        out_row_number <= rows_wide[ROWNUM_W-1:0];
        out_row_sum    <= sum;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/csr_sparse_matvec_rows.sv -----
// CSR sparse matrix-vector multiply, one row sum per result transaction.
// Each input transaction loads a vector entry, streams one nonzero, or marks an empty
// row. A nonzero reads its column from the vector store, the Q15.16 value is
// multiplied by the Q1.30 entry, and the Q17.46 product adds into a saturating
// 64-bit row accumulator. A nonzero with tlast set, or an empty-row command, emits
// the row number and sum and clears the accumulator. The block takes one
// transaction per cycle; the transaction that closes a row passes the read and
// product stages before its result enters the output register. The input stalls
// only when a finished row meets an output register still held by the sink. The
// rate is set by the single read port of the vector store and the saturating add
// of the accumulator loop. Vector entries must be loaded before a nonzero reads
// them; the store has no reset and needs no clearing pass. Loads beyond VECTOR_DEPTH
// are dropped and such columns contribute zero; command 3 is ignored.
// Depends on csrmv_pkg, csrmv_vec_mem and csrmv_mac.
`default_nettype none

module csr_sparse_matvec_rows
  import csrmv_pkg::*;
#(
  parameter int VECTOR_DEPTH     = VECTOR_DEPTH_DEF,
  parameter int ROW_NUMBER_LIMIT = ROW_NUMBER_LIMIT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // index[11:0], operand[43:12], zero pad
  input  wire logic [CMD_W-1:0]     s_axis_tuser,  // command[1:0]
  input  wire logic                 s_axis_tlast,  // row_end
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [M_TDATA_W-1:0] m_axis_tdata   // row_number[15:0], row_sum[79:16]
);

  localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic                     accept;
  logic                     advance;
  cmd_t                     cmd;
  logic [IDX_W-1:0]         idx;
  logic signed [OPND_W-1:0] opnd;
  logic [31:0]              idx_wide;
  logic                     in_range;
  logic [ADDR_W-1:0]        addr;
  logic                     mem_wr;
  logic signed [OPND_W-1:0] vec_data;
  rd_ctl_t                  rd_ctl;
  logic signed [OPND_W-1:0] rd_operand;
  logic [ROWNUM_W-1:0]      out_row_number;
  logic signed [SUM_W-1:0]  out_row_sum;

  // Unpack the input transaction
  always_comb begin
    cmd      = cmd_t'(s_axis_tuser);
    idx      = s_axis_tdata[IDX_W-1:0];
    opnd     = s_axis_tdata[IDX_W+OPND_W-1:IDX_W];
    idx_wide = 32'(idx);
    in_range = idx_wide < 32'(VECTOR_DEPTH);
    addr     = idx_wide[ADDR_W-1:0];
    s_axis_tready = advance;
    accept   = s_axis_tvalid && s_axis_tready;
    mem_wr   = accept && (cmd == CMD_LOAD) && in_range;
  end

  // Loads write at their accept edge; a later term reads at its own accept edge,
  // so a read never overlaps a pending write to the same entry.
  csrmv_vec_mem #(
    .DEPTH  (VECTOR_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (OPND_W)
  ) u_vec_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (addr),
    .wr_data (opnd),
    .rd_en   (accept),
    .rd_addr (addr),
    .rd_data (vec_data)
  );

  // Read stage: hold the item alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl.valid <= 1'b0;
    end else if (advance) begin
      rd_ctl.valid <= accept && ((cmd == CMD_TERM) || (cmd == CMD_EMPTY));
    end
    if (advance) begin
      rd_ctl.term     <= cmd == CMD_TERM;
      rd_ctl.finish   <= (cmd == CMD_EMPTY) || ((cmd == CMD_TERM) && s_axis_tlast);
      rd_ctl.in_range <= in_range;
      rd_operand      <= opnd;
    end
  end

  csrmv_mac #(
    .ROW_NUMBER_LIMIT (ROW_NUMBER_LIMIT)
  ) u_mac (
    .clk            (clk),
    .rst            (rst),
    .rd_ctl         (rd_ctl),
    .rd_operand     (rd_operand),
    .vec_data       (vec_data),
    .advance        (advance),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_row_number (out_row_number),
    .out_row_sum    (out_row_sum)
  );

  assign m_axis_tdata = {out_row_sum, out_row_number};

endmodule

`default_nettype wire

// ----- sv/csrmv_checker.sv -----
// Port-level checks for csr_sparse_matvec_rows, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module csrmv_checker #(
  parameter int ROW_NUMBER_LIMIT = 65536
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata
);

  logic [31:0] rows_seen;
  logic [31:0] rows_seen_next;

  always_comb begin
    rows_seen_next = (rows_seen == 32'(ROW_NUMBER_LIMIT - 1)) ? '0 : rows_seen + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_seen <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rows_seen <= rows_seen_next;
    end
  end

  // No result right after reset
  a_idle_after_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A held result keeps its data
  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Input backpressure only comes from a full, blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // Row numbers count result transactions
  a_row_number: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:0] == rows_seen[15:0])
    else $error("row number out of sequence");

endmodule

bind csr_sparse_matvec_rows csrmv_checker #(
  .ROW_NUMBER_LIMIT (ROW_NUMBER_LIMIT)
) u_csrmv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
